// File: rtl/weighted_gray_box_filter_unit_defines.svh
// Assertion macros shared by the weighted gray box filter RTL.
`ifndef WEIGHTED_GRAY_BOX_FILTER_UNIT_DEFINES_SVH
`define WEIGHTED_GRAY_BOX_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define WGBF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("weighted gray box filter: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define WGBF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("weighted gray box filter: next-cycle check failed");

`endif

// File: rtl/wgbf_pkg.sv
// Shared constants of the weighted gray box filter.
package wgbf_pkg;

    localparam int PIX_W    = 8;
    localparam int LW_W     = 12;
    localparam int ROW_W    = 11;
    localparam int COORD_W  = 11;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int LW_MIN   = 2;

    localparam logic [LW_W-1:0]   LW_RESET        = 12'd640;
    localparam logic [ROW_W-1:0]  ROW_MAX         = 11'd2047;
    localparam logic [APB_AW-1:0] ADDR_LINE_WIDTH = 3'd0;

endpackage

// File: rtl/wgbf_line_mem.sv
// Line memory with one write port and one registered read port.
module wgbf_line_mem #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/weighted_gray_box_filter_unit.sv
// Top level of the weighted gray box filter: gray conversion, box mean and coordinates.
// Each beat passes the input register, then the result register, one beat per cycle
// unless the output stalls. The input register launches the registered line memory
// read, and the sums and the reciprocal multiply settle before the result register.
// Reset is synchronous and active low; it clears the valid flags, the position counters,
// the column sum history and sets line_width to 640. The line memory is not cleared.
module weighted_gray_box_filter_unit #(
    parameter int MASK_SIZE = 2,
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [wgbf_pkg::APB_AW-1:0]     paddr,
    input  logic [wgbf_pkg::APB_DW-1:0]     pwdata,
    output logic [wgbf_pkg::APB_DW-1:0]     prdata,
    output logic                            pready,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [wgbf_pkg::PIX_W-1:0]      i_blue,
    input  logic [wgbf_pkg::PIX_W-1:0]      i_red,
    input  logic                            i_frame_start,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [wgbf_pkg::PIX_W-1:0]      o_weighted_gray,
    output logic [wgbf_pkg::PIX_W-1:0]      o_window_mean,
    output logic                            o_window_full,
    output logic [wgbf_pkg::COORD_W-1:0]    o_centre_row,
    output logic [wgbf_pkg::COORD_W-1:0]    o_centre_col
);
    import wgbf_pkg::*;

    `include "weighted_gray_box_filter_unit_defines.svh"

    localparam int LINES    = (MASK_SIZE > 1) ? MASK_SIZE - 1 : 1;
    localparam int LS_W     = LINES * PIX_W;
    localparam int AW       = $clog2(MAX_WIDTH);
    localparam int MW_W     = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W    = ((MW_W > LW_W) ? MW_W : LW_W) + 1;
    localparam int CSUM_W   = $clog2(MASK_SIZE * 255 + 1);
    localparam int WSUM_W   = $clog2(MASK_SIZE * MASK_SIZE * 255 + 1);
    localparam int DIVISOR  = MASK_SIZE * MASK_SIZE;
    localparam int DIV_LOG  = $clog2(DIVISOR);
    localparam int DIV_SH   = WSUM_W + DIV_LOG + 1;
    localparam int RCP_W    = DIV_SH - DIV_LOG + 1;
    localparam int RECIP_I  = ((2 ** DIV_SH) + DIVISOR - 1) / DIVISOR;
    localparam int PROD_W   = WSUM_W + RCP_W;
    localparam int EDGE     = MASK_SIZE - 1;
    localparam int HALF     = (MASK_SIZE - 1) / 2;

    localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_I);

    function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] b,
                                                 input logic [PIX_W-1:0] r);
        logic [PIX_W+1:0] t;
        t = {1'b0, b, 1'b0} - {2'b00, r};
        if (t[PIX_W+1]) begin
            return '0;
        end else if (t[PIX_W]) begin
            return '1;
        end else begin
            return t[PIX_W-1:0];
        end
    endfunction

    function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
        return (r == ROW_MAX) ? r : r + 1'b1;
    endfunction

    // Configuration.
    logic [LW_W-1:0]  r_line_width;
    logic [CMP_W-1:0] eff_width;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_LINE_WIDTH);
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LINE_WIDTH) ? APB_DW'(r_line_width) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LW_RESET;
        end else if (cfg_wr) begin
            r_line_width <= pwdata[LW_W-1:0];
        end
    end

    always_comb begin
        if (CMP_W'(r_line_width) < CMP_W'(LW_MIN)) begin
            eff_width = CMP_W'(LW_MIN);
        end else if (CMP_W'(r_line_width) > CMP_W'(MAX_WIDTH)) begin
            eff_width = CMP_W'(MAX_WIDTH);
        end else begin
            eff_width = CMP_W'(r_line_width);
        end
    end

    // Handshake.
    logic r_s1_valid;
    logic r_out_valid;
    logic out_ready;
    logic s1_adv;
    logic acc;

    assign out_ready = !r_out_valid || i_ready;
    assign s1_adv    = r_s1_valid && out_ready;
    assign o_ready   = !r_s1_valid || out_ready;
    assign acc       = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pixel position at the input.
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] pos_row;
    logic [AW-1:0]    pos_col;
    logic [ROW_W-1:0] n_row;
    logic [AW-1:0]    n_col;
    logic [CMP_W-1:0] col_next;

    always_comb begin
        if (i_frame_start) begin
            pos_row = '0;
            pos_col = '0;
        end else if (CMP_W'(r_col) >= eff_width) begin
            pos_row = row_inc(r_row);
            pos_col = '0;
        end else begin
            pos_row = r_row;
            pos_col = r_col;
        end
        col_next = CMP_W'(pos_col) + 1'b1;
        if (col_next >= eff_width) begin
            n_row = row_inc(pos_row);
            n_col = '0;
        end else begin
            n_row = pos_row;
            n_col = col_next[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (acc) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // Input register: column and window sums, line memory update, mean.
    logic [PIX_W-1:0]  r_s1_gray;
    logic [ROW_W-1:0]  r_s1_row;
    logic [AW-1:0]     r_s1_col;
    logic              r_s1_fwd;
    logic [LS_W-1:0]   r_fwd_data;
    logic [LS_W-1:0]   ls_rdata;
    logic [LS_W-1:0]   ls_line;
    logic [LS_W-1:0]   ls_wdata;
    logic [CSUM_W-1:0] r_hist [LINES];
    logic [CSUM_W-1:0] s1_csum;
    logic [WSUM_W-1:0] s1_hsum;
    logic [WSUM_W-1:0] s1_wsum;
    logic              s1_full;
    logic [ROW_W-1:0]  s1_crow;
    logic [CMP_W-1:0]  s1_ccol;
    logic [PROD_W-1:0] s1_prod;

    wgbf_line_mem #(
        .DATA_W (LS_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata (ls_wdata),
        .i_re    (acc),
        .i_raddr (pos_col),
        .o_rdata (ls_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_gray  <= gray_of(i_blue, i_red);
            r_s1_row   <= pos_row;
            r_s1_col   <= pos_col;
            r_s1_fwd   <= r_s1_valid && (pos_col == r_s1_col);
            r_fwd_data <= ls_wdata;
        end
    end

    assign ls_line = r_s1_fwd ? r_fwd_data : ls_rdata;

    always_comb begin
        ls_wdata = ls_line;
        ls_wdata[PIX_W-1:0] = r_s1_gray;
        for (int k = 1; k < LINES; k++) begin
            ls_wdata[k*PIX_W +: PIX_W] = ls_line[(k-1)*PIX_W +: PIX_W];
        end
    end

    always_comb begin
        s1_csum = CSUM_W'(r_s1_gray);
        s1_hsum = '0;
        for (int k = 0; k < MASK_SIZE - 1; k++) begin
            s1_csum = s1_csum + CSUM_W'(ls_line[k*PIX_W +: PIX_W]);
            s1_hsum = s1_hsum + WSUM_W'(r_hist[k]);
        end
        s1_wsum = WSUM_W'(s1_csum) + s1_hsum;
        s1_full = (r_s1_row >= ROW_W'(EDGE)) && (CMP_W'(r_s1_col) >= CMP_W'(EDGE));
        s1_crow = r_s1_row - ROW_W'(EDGE) + ROW_W'(HALF);
        s1_ccol = CMP_W'(r_s1_col) - CMP_W'(EDGE) + CMP_W'(HALF);
    end

    assign s1_prod = PROD_W'(s1_wsum) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LINES; k++) begin
                r_hist[k] <= '0;
            end
        end else if (s1_adv) begin
            r_hist[0] <= s1_csum;
            for (int k = 1; k < LINES; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

    // Output register.
    logic [PIX_W-1:0]   r_out_gray;
    logic [PIX_W-1:0]   r_out_mean;
    logic               r_out_full;
    logic [ROW_W-1:0]   r_out_crow;
    logic [COORD_W-1:0] r_out_ccol;

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_gray <= r_s1_gray;
            r_out_mean <= s1_full ? s1_prod[DIV_SH +: PIX_W] : '0;
            r_out_full <= s1_full;
            r_out_crow <= s1_full ? s1_crow : '0;
            r_out_ccol <= s1_full ? s1_ccol[COORD_W-1:0] : '0;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_weighted_gray = r_out_gray;
    assign o_window_mean   = r_out_mean;
    assign o_window_full   = r_out_full;
    assign o_centre_row    = r_out_crow;
    assign o_centre_col    = r_out_ccol;

    `WGBF_ASSERT_NEXT(a_fwd_same_col, acc && r_s1_valid && (pos_col == r_s1_col), r_s1_fwd)
    `WGBF_ASSERT_NOW(a_stall_only_full, !o_ready, r_s1_valid && r_out_valid && !i_ready)
    `WGBF_ASSERT_NOW(a_partial_window_zero, o_valid && !o_window_full,
                     {o_window_mean, o_centre_row, o_centre_col} == '0)

endmodule

// File: sim/weighted_gray_box_filter_unit_tb.sv
// Self-checking testbench for the weighted gray box filter unit with a built-in pixel predictor.
module weighted_gray_box_filter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wgbf_pkg::*;

    localparam int MASK_SIZE = 2;
    localparam int MAX_WIDTH = 2048;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] red;
        logic             fs;
    } t_pix_item;

    typedef struct packed {
        logic [PIX_W-1:0]   gray;
        logic [PIX_W-1:0]   mean;
        logic               full;
        logic [COORD_W-1:0] crow;
        logic [COORD_W-1:0] ccol;
    } t_filt_res;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [APB_AW-1:0]    paddr = '0;
    logic [APB_DW-1:0]    pwdata = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic [PIX_W-1:0]     i_blue = '0;
    logic [PIX_W-1:0]     i_red = '0;
    logic                 i_frame_start = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [PIX_W-1:0]     o_weighted_gray;
    logic [PIX_W-1:0]     o_window_mean;
    logic                 o_window_full;
    logic [COORD_W-1:0]   o_centre_row;
    logic [COORD_W-1:0]   o_centre_col;

    weighted_gray_box_filter_unit #(
        .MASK_SIZE (MASK_SIZE),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_blue          (i_blue),
        .i_red           (i_red),
        .i_frame_start   (i_frame_start),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_weighted_gray (o_weighted_gray),
        .o_window_mean   (o_window_mean),
        .o_window_full   (o_window_full),
        .o_centre_row    (o_centre_row),
        .o_centre_col    (o_centre_col)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_pix_item pix_pend_q[$];
    t_filt_res exp_pix_q[$];

    logic [LW_W-1:0]  lw_cfg = LW_RESET;
    logic [PIX_W-1:0] line_hist [MASK_SIZE][MAX_WIDTH] = '{default: '0};
    logic [10:0]      colsum_hist [MASK_SIZE] = '{default: '0};
    int               row_pos = 0;
    int               col_pos = 0;

    int n_err = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_widths = 0;
    int burst_left = 1;
    int gap_left = 0;
    int rdy_mode = 0;
    int rdy_left = 0;
    int cyc = 0;

    function automatic void flag_error(string msg);
        n_err++;
        if (n_err <= 10) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    function automatic int eff_line_width(logic [LW_W-1:0] w);
        int v;
        v = int'(w);
        if (v < LW_MIN) v = LW_MIN;
        if (v > MAX_WIDTH) v = MAX_WIDTH;
        return v;
    endfunction

    function automatic t_filt_res filter_predict(logic [PIX_W-1:0] b, logic [PIX_W-1:0] r,
                                                 logic fs);
        int        w, g, row, col, csum, wsum, k;
        logic      full;
        t_filt_res res;
        w = eff_line_width(lw_cfg);
        g = 2 * int'(b) - int'(r);
        if (g < 0) g = 0;
        if (g > 255) g = 255;
        if (fs) begin
            row = 0;
            col = 0;
        end else begin
            row = row_pos;
            col = col_pos;
            if (col >= w) begin
                col = 0;
                if (row < int'(ROW_MAX)) row++;
            end
        end
        csum = g;
        for (k = 0; k < MASK_SIZE - 1; k++) csum += int'(line_hist[k][col]);
        for (k = MASK_SIZE - 2; k >= 1; k--) line_hist[k][col] = line_hist[k-1][col];
        if (MASK_SIZE > 1) line_hist[0][col] = g[PIX_W-1:0];
        wsum = csum;
        for (k = 0; k < MASK_SIZE - 1; k++) wsum += int'(colsum_hist[k]);
        for (k = MASK_SIZE - 2; k >= 1; k--) colsum_hist[k] = colsum_hist[k-1];
        if (MASK_SIZE > 1) colsum_hist[0] = csum[10:0];
        full = (row >= MASK_SIZE - 1) && (col >= MASK_SIZE - 1);
        res = '0;
        res.gray = g[PIX_W-1:0];
        if (full) begin
            wsum = wsum / (MASK_SIZE * MASK_SIZE);
            k = row - (MASK_SIZE - 1) + (MASK_SIZE - 1) / 2;
            res.mean = wsum[PIX_W-1:0];
            res.full = 1'b1;
            res.crow = k[COORD_W-1:0];
            k = col - (MASK_SIZE - 1) + (MASK_SIZE - 1) / 2;
            res.ccol = k[COORD_W-1:0];
            n_full++;
        end
        col++;
        if (col >= w) begin
            col = 0;
            if (row < int'(ROW_MAX)) row++;
        end
        row_pos = row;
        col_pos = col;
        return res;
    endfunction

    // Pixel sender: bursts of beats, usually separated by idle gaps.
    always @(posedge i_clk) begin : drv_proc
        t_pix_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                exp_pix_q.push_back(filter_predict(i_blue, i_red, i_frame_start));
                n_sent++;
            end
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pix_pend_q.size() > 0) begin
                    nxt = pix_pend_q.pop_front();
                    i_blue <= nxt.blue;
                    i_red <= nxt.red;
                    i_frame_start <= nxt.fs;
                    i_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: checks each beat and stalls on a changing pattern.
    always @(posedge i_clk) begin : mon_proc
        t_filt_res got;
        t_filt_res want;
        logic      rdy;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            cyc++;
            if (o_valid && i_ready) begin
                got = '{o_weighted_gray, o_window_mean, o_window_full,
                        o_centre_row, o_centre_col};
                if (exp_pix_q.size() == 0) begin
                    flag_error($sformatf("result beat with no pixel pending: gray %0d mean %0d",
                                         got.gray, got.mean));
                end else begin
                    want = exp_pix_q.pop_front();
                    if (got !== want) begin
                        flag_error($sformatf({"result %0d: expected gray %0d mean %0d full %0b ",
                            "row %0d col %0d, got gray %0d mean %0d full %0b row %0d col %0d"},
                            n_checked, want.gray, want.mean, want.full, want.crow, want.ccol,
                            got.gray, got.mean, got.full, got.crow, got.ccol));
                    end
                    n_checked++;
                end
            end
            if (rdy_left == 0) begin
                rdy_mode = $urandom_range(0, 3);
                rdy_left = $urandom_range(10, 120);
            end else begin
                rdy_left--;
            end
            case (rdy_mode)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2: rdy = (cyc % 5) != 0;
                default: rdy = (cyc % 9) == 8;
            endcase
            i_ready <= rdy;
        end
    end

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_read(logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_width_reg(logic [LW_W-1:0] want);
        logic [APB_DW-1:0] rd;
        apb_read(ADDR_LINE_WIDTH, rd);
        if (rd[LW_W-1:0] !== want) begin
            flag_error($sformatf("line_width read back %0d, expected %0d", rd[LW_W-1:0], want));
        end
    endtask

    task automatic set_width(logic [LW_W-1:0] w);
        apb_write(ADDR_LINE_WIDTH, APB_DW'(w));
        lw_cfg = w;
        n_widths++;
        check_width_reg(w);
    endtask

    task automatic wait_drained();
        do begin
            @(negedge i_clk);
        end while (pix_pend_q.size() != 0 || i_valid || exp_pix_q.size() != 0);
    endtask

    task automatic push_pix(logic [PIX_W-1:0] b, logic [PIX_W-1:0] r, logic fs);
        pix_pend_q.push_back('{b, r, fs});
    endtask

    function automatic logic [PIX_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    // A wider line inside a frame would read columns never stored, so growth restarts the frame.
    task automatic run_phase(logic [LW_W-1:0] w, int n);
        logic grow;
        logic fs;
        grow = eff_line_width(w) > eff_line_width(lw_cfg);
        set_width(w);
        for (int i = 0; i < n; i++) begin
            if (i == 0) fs = grow || ($urandom_range(0, 1) == 1);
            else fs = ($urandom_range(0, 49) == 0);
            push_pix(rand_byte(), rand_byte(), fs);
        end
        wait_drained();
    endtask

    initial begin : stim_proc
        logic [LW_W-1:0] w;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        check_width_reg(LW_RESET);
        set_width(12'd3);
        push_pix(8'd255, 8'd0, 1'b1);
        push_pix(8'd0, 8'd255, 1'b0);
        push_pix(8'd128, 8'd1, 1'b0);
        push_pix(8'd100, 8'd50, 1'b0);
        push_pix(8'd0, 8'd0, 1'b0);
        push_pix(8'd255, 8'd255, 1'b0);
        push_pix(8'd64, 8'd128, 1'b0);
        push_pix(8'd127, 8'd0, 1'b0);
        push_pix(8'd200, 8'd145, 1'b0);
        push_pix(8'd10, 8'd5, 1'b0);
        push_pix(8'd50, 8'd20, 1'b1);
        repeat (5) push_pix(8'd255, 8'd0, 1'b0);
        wait_drained();

        // Shrinking the line width; the current column is 0 here, so no line is cut short.
        set_width(12'd2);
        repeat (6) push_pix(rand_byte(), rand_byte(), 1'b0);
        wait_drained();

        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 5))
                0: w = LW_W'($urandom_range(0, 1));
                1: w = 12'd2;
                2: w = LW_W'($urandom_range(3, 8));
                3: w = LW_W'($urandom_range(2, 32));
                4: w = LW_W'($urandom_range(9, 64));
                default: w = LW_W'($urandom_range(3, 16));
            endcase
            run_phase(w, $urandom_range(25, 60));
        end

        run_phase(12'd4095, 20);
        run_phase(12'd2048, 10);
        run_phase(12'd0, 30);

        repeat (10) @(posedge i_clk);
        $display("Summary: %0d pixels sent, %0d results checked, %0d full windows.",
                 n_sent, n_checked, n_full);
        $display("Summary: %0d line_width settings, clamped ones too, with frame restarts.",
                 n_widths);
        if (n_err == 0) begin
            $display("weighted_gray_box_filter_unit verification clean");
        end else begin
            $display("Mismatches: %0d", n_err);
            $display("weighted_gray_box_filter_unit verification failed");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #10_000_000;
        $display("Timeout: %0d results still pending", exp_pix_q.size());
        $display("weighted_gray_box_filter_unit verification failed");
        $finish;
    end

endmodule
